// ===== sv/pth_pkg.sv =====
// ---------------------------------------------------------------------------
// pth_pkg - shared types and constants for the pixel to hex cell mapper
// Candidate word for the nearest-centre search, register codes, fixed widths.
// ---------------------------------------------------------------------------
`default_nettype none

package pth_pkg;

	// output field width
	localparam int OUT_W  = 13;
	// clamped distance component, its square and the sum of two squares
	localparam int MAG_W  = 31;
	localparam int SQ_W   = 2 * MAG_W;
	localparam int DIST_W = SQ_W + 1;

	// search window: 3 columns by 5 rows
	localparam int N_COL  = 3;
	localparam int N_ROW  = 5;
	localparam int N_CAND = N_COL * N_ROW;

	// starting best distance is (hex_size * DIST_FACTOR)^2
	localparam logic [15:0] DIST_FACTOR = 16'd200;
	localparam logic [MAG_W-1:0] COMP_CLAMP = '1;

	// register map (index = paddr[3:2])
	localparam logic [1:0] REG_HEX_SIZE    = 2'd0;
	localparam logic [1:0] REG_HALF_HEIGHT = 2'd1;
	localparam logic [1:0] REG_OFFSET_X    = 2'd2;
	localparam logic [1:0] REG_OFFSET_Y    = 2'd3;

	localparam logic [7:0] HEX_SIZE_RST    = 8'd12;
	localparam logic [7:0] HALF_HEIGHT_RST = 8'd10;

	// one candidate cell: valid, squared distance, column and row offset in window
	typedef struct packed {
		logic              v;
		logic [DIST_W-1:0] d;
		logic [1:0]        ci;
		logic [2:0]        rj;
	} cand_t;

	// keep the earlier candidate unless it is invalid or the later one is valid and strictly nearer
	function automatic cand_t cand_pick(input cand_t a, input cand_t b);
		cand_t res;
		res = a;
		if (b.v && (!a.v || (b.d < a.d))) begin
			res = b;
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// ===== sv/pixel_to_hex_cell.sv =====
// ---------------------------------------------------------------------------
// pixel_to_hex_cell - nearest hex cell centre for a window pixel position
// Offset add, pipelined bit-serial dividers, distance and min-search pipeline.
// ---------------------------------------------------------------------------
// Usage:
//   Input words (pix_x, pix_y) enter on in_valid/in_ready, result words
//   (cell_col, cell_row) leave on out_valid/out_ready. Configuration is
//   written over the APB port while no word is in flight.
//   The two restoring dividers work on NW = max(COORD_WIDTH, 17) + 2 bit
//   words, retire one quotient bit per stage and set most of the pipeline
//   depth; the rest is the offset add, the sign fix, multipliers, squares
//   and a four-level compare tree.
//   Throughput is one word per cycle: a new word may enter every cycle while the pipeline is not held.
//   When out_ready is low with a result waiting, the whole pipeline holds
//   and in_ready falls; no word is lost or repeated.
//   Reset empties the pipeline and loads hex_size 12, half_height 10 and
//   zero offsets.
// ---------------------------------------------------------------------------
`default_nettype none

module pixel_to_hex_cell
	import pth_pkg::*;
#(
	parameter int COORD_WIDTH = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [3:0]                    paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready,
	// input words
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [COORD_WIDTH-1:0] pix_x,
	input  wire logic signed [COORD_WIDTH-1:0] pix_y,
	// result words
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [OUT_W-1:0]            cell_col,
	output logic signed [OUT_W-1:0]            cell_row
);

	localparam int XW  = (COORD_WIDTH > 17) ? COORD_WIDTH : 17;
	localparam int AW  = XW + 1;   // map coordinate
	localparam int NW  = AW + 1;   // dividend, quotient
	localparam int CCW = NW + 1;   // candidate column
	localparam int PW  = CCW + 11; // column * hex_size * 3
	localparam int DXW = PW + 2;   // x distance
	localparam int RRW = NW + 2;   // candidate row + 1
	localparam int QRW = RRW + 9;  // (row + 1) * half_height
	localparam int DYW = QRW + 1;  // y distance

	typedef struct packed {
		logic                 v;
		logic [NW-1:0]        wx;
		logic [NW-1:0]        wy;
		logic [8:0]           rx;
		logic [8:0]           ry;
		logic                 sx;
		logic                 sy;
		logic signed [AW-1:0] ax;
		logic signed [AW-1:0] ay;
	} div_t;

	// configuration registers
	logic        [7:0]  hs_q;
	logic        [7:0]  hh_q;
	logic signed [16:0] ox_q;
	logic signed [16:0] oy_q;

	logic              cfg_wr;
	logic [9:0]        hs3;
	logic [8:0]        pitch;
	logic signed [10:0] hs3_sg;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign hs3    = 10'(hs_q) * 10'd3;
	assign pitch  = hs3[9:1];
	assign hs3_sg = $signed({1'b0, hs3});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hs_q <= HEX_SIZE_RST;
			hh_q <= HALF_HEIGHT_RST;
			ox_q <= '0;
			oy_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_HEX_SIZE:    hs_q <= pwdata[7:0];
				REG_HALF_HEIGHT: hh_q <= pwdata[7:0];
				REG_OFFSET_X:    ox_q <= $signed(pwdata[16:0]);
				REG_OFFSET_Y:    oy_q <= $signed(pwdata[16:0]);
				default:         ;
			endcase
		end
	end

	// register read back
	always_comb begin
		unique case (paddr[3:2])
			REG_HEX_SIZE:    prdata = {24'd0, hs_q};
			REG_HALF_HEIGHT: prdata = {24'd0, hh_q};
			REG_OFFSET_X:    prdata = 32'(ox_q);
			REG_OFFSET_Y:    prdata = 32'(oy_q);
			default:         prdata = '0;
		endcase
	end

	// global advance: the pipeline moves unless a result is waiting and out_ready is low
	logic adv;
	logic v_s12;

	assign adv       = !v_s12 || out_ready;
	assign in_ready  = adv;
	assign out_valid = v_s12;

	// stage 1: map coordinates and dividends
	logic                 v_s1;
	logic signed [AW-1:0] ax_s1, ay_s1;
	logic signed [NW-1:0] nx_s1, ny_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s1 <= AW'(pix_x) + AW'(ox_q);
			ay_s1 <= AW'(pix_y) + AW'(oy_q);
			nx_s1 <= NW'(pix_x) + NW'(ox_q) - NW'($signed({1'b0, hs_q}));
			ny_s1 <= NW'(pix_y) + NW'(oy_q) - NW'($signed({1'b0, hh_q}));
		end
	end

	// one restoring step on both dividers
	function automatic div_t div_step(input div_t d, input logic [8:0] dvx,
		input logic [8:0] dvy);
		div_t       res;
		logic [9:0] rem_x;
		logic [9:0] rem_y;
		res   = d;
		rem_x = {d.rx, d.wx[NW-1]};
		rem_y = {d.ry, d.wy[NW-1]};
		if (rem_x >= {1'b0, dvx}) begin
			res.rx = 9'(rem_x - {1'b0, dvx});
			res.wx = {d.wx[NW-2:0], 1'b1};
		end else begin
			res.rx = rem_x[8:0];
			res.wx = {d.wx[NW-2:0], 1'b0};
		end
		if (rem_y >= {1'b0, dvy}) begin
			res.ry = 9'(rem_y - {1'b0, dvy});
			res.wy = {d.wy[NW-2:0], 1'b1};
		end else begin
			res.ry = rem_y[8:0];
			res.wy = {d.wy[NW-2:0], 1'b0};
		end
		return res;
	endfunction

	// divider pipeline: entry 0 loads magnitudes, each later entry one bit
	div_t dv_sd [NW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= NW; k++) begin
				dv_sd[k] <= '0;
			end
		end else if (adv) begin
			dv_sd[0].v  <= v_s1;
			dv_sd[0].wx <= nx_s1[NW-1] ? NW'(-nx_s1) : NW'(nx_s1);
			dv_sd[0].wy <= ny_s1[NW-1] ? NW'(-ny_s1) : NW'(ny_s1);
			dv_sd[0].rx <= '0;
			dv_sd[0].ry <= '0;
			dv_sd[0].sx <= nx_s1[NW-1];
			dv_sd[0].sy <= ny_s1[NW-1];
			dv_sd[0].ax <= ax_s1;
			dv_sd[0].ay <= ay_s1;
			for (int k = 0; k < NW; k++) begin
				dv_sd[k+1] <= div_step(dv_sd[k], pitch, {1'b0, hh_q});
			end
		end
	end

	// stage 3: signed quotients, zero divisor gives zero
	logic                 v_s3;
	logic signed [NW-1:0] ac_s3, ar_s3;
	logic signed [AW-1:0] ax_s3, ay_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= dv_sd[NW].v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (pitch == '0) begin
				ac_s3 <= '0;
			end else begin
				ac_s3 <= dv_sd[NW].sx ? -$signed(dv_sd[NW].wx) : $signed(dv_sd[NW].wx);
			end
			if (hh_q == '0) begin
				ar_s3 <= '0;
			end else begin
				ar_s3 <= dv_sd[NW].sy ? -$signed(dv_sd[NW].wy) : $signed(dv_sd[NW].wy);
			end
			ax_s3 <= dv_sd[NW].ax;
			ay_s3 <= dv_sd[NW].ay;
		end
	end

	// approximate cell carried to the end (entry k is stage 4 + k)
	logic signed [NW-1:0] acp_s [8];
	logic signed [NW-1:0] arp_s [8];

	always_ff @(posedge clk) begin
		if (adv) begin
			acp_s[0] <= ac_s3;
			arp_s[0] <= ar_s3;
			for (int k = 1; k < 8; k++) begin
				acp_s[k] <= acp_s[k-1];
				arp_s[k] <= arp_s[k-1];
			end
		end
	end

	// stage 4: centre products
	logic signed [CCW-1:0] c_w  [N_COL];
	logic signed [RRW-1:0] r1_w [N_ROW];

	always_comb begin
		for (int i = 0; i < N_COL; i++) begin
			c_w[i] = CCW'(ac_s3) + CCW'(i - 1);
		end
		for (int j = 0; j < N_ROW; j++) begin
			r1_w[j] = RRW'(ar_s3) + RRW'(j - 1);
		end
	end

	logic                  v_s4;
	logic signed [PW-1:0]  pc_s4 [N_COL];
	logic signed [QRW-1:0] qr_s4 [N_ROW];
	logic signed [AW-1:0]  ax_s4, ay_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < N_COL; i++) begin
				pc_s4[i] <= PW'(c_w[i]) * PW'(hs3_sg);
			end
			for (int j = 0; j < N_ROW; j++) begin
				qr_s4[j] <= QRW'(r1_w[j]) * QRW'($signed({1'b0, hh_q}));
			end
			ax_s4 <= ax_s3;
			ay_s4 <= ay_s3;
		end
	end

	// stage 5: clamped distance components
	logic signed [PW:0]    hx_w  [N_COL];
	logic signed [DXW-1:0] dxd_w [N_COL];
	logic        [DXW-1:0] adx_w [N_COL];
	logic signed [DYW-1:0] dyd_w [N_ROW];
	logic        [DYW-1:0] ady_w [N_ROW];

	always_comb begin
		for (int i = 0; i < N_COL; i++) begin
			// halve, rounding toward zero
			hx_w[i]  = (PW+1)'(pc_s4[i] >>> 1)
				+ (PW+1)'($signed({1'b0, pc_s4[i][PW-1] & pc_s4[i][0]}));
			dxd_w[i] = DXW'(hx_w[i]) + DXW'($signed({1'b0, hs_q})) - DXW'(ax_s4);
			adx_w[i] = dxd_w[i][DXW-1] ? DXW'(-dxd_w[i]) : DXW'(dxd_w[i]);
		end
		for (int j = 0; j < N_ROW; j++) begin
			dyd_w[j] = DYW'(qr_s4[j]) - DYW'(ay_s4);
			ady_w[j] = dyd_w[j][DYW-1] ? DYW'(-dyd_w[j]) : DYW'(dyd_w[j]);
		end
	end

	logic             v_s5;
	logic [MAG_W-1:0] dx_s5 [N_COL];
	logic [MAG_W-1:0] dy_s5 [N_ROW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < N_COL; i++) begin
				dx_s5[i] <= (adx_w[i] > DXW'(COMP_CLAMP)) ? COMP_CLAMP : adx_w[i][MAG_W-1:0];
			end
			for (int j = 0; j < N_ROW; j++) begin
				dy_s5[j] <= (ady_w[j] > DYW'(COMP_CLAMP)) ? COMP_CLAMP : ady_w[j][MAG_W-1:0];
			end
		end
	end

	// stage 6: squares
	logic            v_s6;
	logic [SQ_W-1:0] sqx_s6 [N_COL];
	logic [SQ_W-1:0] sqy_s6 [N_ROW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < N_COL; i++) begin
				sqx_s6[i] <= SQ_W'(dx_s5[i]) * SQ_W'(dx_s5[i]);
			end
			for (int j = 0; j < N_ROW; j++) begin
				sqy_s6[j] <= SQ_W'(dy_s5[j]) * SQ_W'(dy_s5[j]);
			end
		end
	end

	// stage 7: candidate distances, column plus row must be even
	logic  v_s7;
	logic  par_w;
	cand_t cand_s7 [N_CAND];

	assign par_w = acp_s[2][0] ^ arp_s[2][0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < N_COL; i++) begin
				for (int j = 0; j < N_ROW; j++) begin
					cand_s7[i*N_ROW+j].v  <= ~(par_w ^ 1'(i + j + 1));
					cand_s7[i*N_ROW+j].d  <= DIST_W'(sqx_s6[i]) + DIST_W'(sqy_s6[j]);
					cand_s7[i*N_ROW+j].ci <= 2'(i);
					cand_s7[i*N_ROW+j].rj <= 3'(j);
				end
			end
		end
	end

	// stages 8 to 11: compare tree, earlier candidate kept on a tie
	logic  v_s8, v_s9, v_s10, v_s11;
	cand_t cand_s8  [8];
	cand_t cand_s9  [4];
	cand_t cand_s10 [2];
	cand_t cand_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else if (adv) begin
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 7; k++) begin
				cand_s8[k] <= cand_pick(cand_s7[2*k], cand_s7[2*k+1]);
			end
			cand_s8[7] <= cand_s7[N_CAND-1];
			for (int k = 0; k < 4; k++) begin
				cand_s9[k] <= cand_pick(cand_s8[2*k], cand_s8[2*k+1]);
			end
			for (int k = 0; k < 2; k++) begin
				cand_s10[k] <= cand_pick(cand_s9[2*k], cand_s9[2*k+1]);
			end
			cand_s11 <= cand_pick(cand_s10[0], cand_s10[1]);
		end
	end

	// stage 12: compare with the starting limit, fall back to the approximate cell
	logic [15:0]    lim_w;
	logic [31:0]    best_w;
	logic           take_w;
	logic [NW-1:0]  col_w, row_w;

	assign lim_w  = 16'(hs_q) * DIST_FACTOR;
	assign best_w = 32'(lim_w) * 32'(lim_w);
	assign take_w = cand_s11.v && (cand_s11.d < DIST_W'(best_w));
	assign col_w  = take_w ? (NW'(acp_s[7]) + NW'(cand_s11.ci) - NW'(1)) : NW'(acp_s[7]);
	assign row_w  = take_w ? (NW'(arp_s[7]) + NW'(cand_s11.rj) - NW'(2)) : NW'(arp_s[7]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s12 <= 1'b0;
		end else if (adv) begin
			v_s12 <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cell_col <= $signed(col_w[OUT_W-1:0]);
			cell_row <= $signed(row_w[OUT_W-1:0]);
		end
	end

	// divider remainder ends below the column pitch
	a_rem_x: assert property (@(posedge clk) disable iff (!arst_n)
		(dv_sd[NW].v && (pitch != '0)) |-> (dv_sd[NW].rx < pitch))
		else $error("column divider remainder not below pitch");

	// every column of the window holds a valid cell, so the tree always has a winner
	a_win: assert property (@(posedge clk) disable iff (!arst_n)
		v_s11 |-> cand_s11.v)
		else $error("compare tree lost every candidate");

	// a stall freezes the candidate stage
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!adv && v_s7) |=> (v_s7 && $stable(cand_s7[0].d) && $stable(cand_s7[N_CAND-1].d)))
		else $error("candidate stage moved during a stall");

endmodule

`default_nettype wire

// ===== verif/tb_pixel_to_hex_cell.sv =====
// ---------------------------------------------------------------------------
// tb_pixel_to_hex_cell - self-checking bench for the pixel to hex cell mapper
// Drives pixel words and APB register writes, predicts the nearest valid hex
// centre for every accepted word and compares each result word in order.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_pixel_to_hex_cell
	import pth_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW        = 16;
	localparam int LATENCY   = 31;
	localparam int WDOG_MAX  = 20000;
	localparam int MAX_SHOWN = 10;

	typedef struct {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
	} pixel_t;

	typedef struct {
		logic signed [OUT_W-1:0] col;
		logic signed [OUT_W-1:0] row;
	} cell_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic in_valid, in_ready;
	logic signed [CW-1:0] pix_x, pix_y;
	logic out_valid, out_ready;
	logic signed [OUT_W-1:0] cell_col, cell_row;

	// acceptance flag seen at the rising edge, used by the driver at the falling edge
	logic in_ready_seen;

	// predictor copy of the registers
	longint unsigned hex_sz, half_ht;
	longint signed off_x, off_y;

	pixel_t pending_px[$];
	cell_t  expected_cells[$];
	int     send_idle_pct, recv_stall_pct;
	int     mismatches;
	int     wdog;
	bit     failed;

	pixel_to_hex_cell #(.COORD_WIDTH(CW)) u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .pix_x(pix_x), .pix_y(pix_y),
		.out_valid(out_valid), .out_ready(out_ready),
		.cell_col(cell_col), .cell_row(cell_row)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic longint unsigned clamp_mag(longint signed d);
		longint unsigned a;
		a = (d < 0) ? longint'(-d) : longint'(d);
		return (a > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : a;
	endfunction

	// nearest valid hex centre in the 3x5 search window
	function automatic cell_t nearest_cell(pixel_t p);
		longint signed ax, ay, hs, hh, pitch, ac, ar, bc, br, c, r, cx, cy;
		longint unsigned lim, best, dx, dy, d2;
		cell_t res;
		ax = longint'(p.x) + off_x;
		ay = longint'(p.y) + off_y;
		hs = hex_sz;
		hh = half_ht;
		pitch = hs * 3 / 2;
		ac = (pitch > 0) ? (ax - hs) / pitch : 0;
		ar = (hh > 0) ? (ay - hh) / hh : 0;
		lim = hex_sz * 200;
		best = lim * lim;
		bc = ac;
		br = ar;
		for (c = ac - 1; c <= ac + 1; c++) begin
			for (r = ar - 2; r <= ar + 2; r++) begin
				if (((c + r) & 1) != 0) continue;
				cx = (c * hs * 3) / 2 + hs;
				cy = r * hh + hh;
				dx = clamp_mag(cx - ax);
				dy = clamp_mag(cy - ay);
				d2 = dx * dx + dy * dy;
				if (d2 < best) begin
					best = d2;
					bc = c;
					br = r;
				end
			end
		end
		res.col = bc[OUT_W-1:0];
		res.row = br[OUT_W-1:0];
		return res;
	endfunction

	// word driver: next pending pixel presented at the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_ready_seen) begin
				if (pending_px.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					pix_x <= pending_px[0].x;
					pix_y <= pending_px[0].y;
					void'(pending_px.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ready_seen <= 1'b0;
		end else begin
			in_ready_seen <= in_valid && in_ready;
		end
	end

	// monitor: predict on input acceptance, check on output acceptance
	always @(posedge clk) begin
		cell_t e;
		bit    took;
		if (arst_n) begin
			took = (in_valid && in_ready) || (out_valid && out_ready);
			wdog <= took ? 0 : wdog + 1;
			if (in_valid && in_ready) begin
				expected_cells.push_back(nearest_cell('{x: pix_x, y: pix_y}));
			end
			if (out_valid && out_ready) begin
				if (expected_cells.size() == 0) begin
					failed = 1'b1;
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("unexpected result word col=%0d row=%0d",
							cell_col, cell_row);
				end else begin
					e = expected_cells.pop_front();
					if (e.col !== cell_col || e.row !== cell_row) begin
						failed = 1'b1;
						mismatches++;
						if (mismatches <= MAX_SHOWN)
							$display("mismatch: expected col=%0d row=%0d, got col=%0d row=%0d",
								e.col, e.row, cell_col, cell_row);
					end
				end
			end
			if (wdog >= WDOG_MAX) begin
				$display("watchdog expired");
				$display("** pixel_to_hex_cell: FAILED **");
				$finish;
			end
		end
	end

	// APB write: setup then access, register taken at the access edge
	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_HEX_SIZE:    hex_sz = val[7:0];
			REG_HALF_HEIGHT: half_ht = val[7:0];
			REG_OFFSET_X:    off_x = longint'($signed(val[16:0]));
			default:         off_y = longint'($signed(val[16:0]));
		endcase
	endtask

	// checked between edges, once the driver and monitor have settled
	task automatic drain;
		do begin
			@(negedge clk);
			#1;
		end while (pending_px.size() != 0 || in_valid || expected_cells.size() != 0);
		repeat (LATENCY + 8) @(negedge clk);
	endtask

	task automatic push_px(int x, int y);
		pending_px.push_back('{x: CW'(x), y: CW'(y)});
	endtask

	// mostly local coordinates so cell boundaries are exercised, some full range
	task automatic random_words(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(3) == 0)
				push_px($urandom, $urandom);
			else
				push_px($signed($urandom_range(2000)) - 1000,
					$signed($urandom_range(2000)) - 1000);
		end
	endtask

	task automatic set_regs(int hs, int hh, int ox, int oy);
		reg_write(REG_HEX_SIZE, hs);
		reg_write(REG_HALF_HEIGHT, hh);
		reg_write(REG_OFFSET_X, ox);
		reg_write(REG_OFFSET_Y, oy);
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		in_valid = 1'b0; pix_x = '0; pix_y = '0; out_ready = 1'b0;
		hex_sz = 12; half_ht = 10; off_x = 0; off_y = 0;
		send_idle_pct = 0; recv_stall_pct = 0;
		mismatches = 0; wdog = 0; failed = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset values, extremes, centres and the origin
		push_px(0, 0); push_px(12, 10); push_px(-1, -1);
		push_px(32767, 32767); push_px(-32768, -32768);
		push_px(32767, -32768); push_px(-32768, 32767);
		push_px(30, 20); push_px(5, 5);
		drain();
		// zero sizes: no winner, approximate cell returned
		set_regs(0, 0, 0, 0);
		push_px(100, -100); push_px(-32768, 32767); push_px(7, 7);
		drain();
		// odd size, extreme offsets
		set_regs(255, 255, 65535, -65536);
		push_px(32767, -32768); push_px(-32768, 32767); push_px(0, 0);
		drain();
		set_regs(1, 1, -65536, 65535);
		push_px(-32768, 32767); push_px(32767, -32768); push_px(3, 3);
		drain();
		set_regs(2, 255, 0, 0);
		push_px(1, 1); push_px(-2, 300); push_px(32767, 0);
		drain();

		// random phases with differing idle profiles and settings
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
				default: begin send_idle_pct = 26; recv_stall_pct = 26; end
			endcase
			if (ph > 0)
				set_regs(($urandom_range(127) * 2) | (ph == 7),
					$urandom_range(255), $urandom, $urandom);
			random_words(85);
			drain();
		end

		if (!failed) begin
			$display("** pixel_to_hex_cell: PASSED **");
		end else begin
			$display("** pixel_to_hex_cell: FAILED **");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== pixel_to_hex_cell.f =====
sv/pth_pkg.sv
sv/pixel_to_hex_cell.sv
verif/tb_pixel_to_hex_cell.sv
